### rtl/ssfr_pkg.sv
// Shared types, character codes and helpers for the servo status frame receiver.
package ssfr_pkg;

  localparam int unsigned FRAME_LEN = 12;
  localparam int unsigned CNT_W     = $clog2(FRAME_LEN);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LEN - 1);

  localparam logic [7:0]  HEADER_RST  = 8'd37;
  localparam logic [15:0] TIMEOUT_RST = 16'd2000;

  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_2 = 8'h32;
  localparam logic [7:0] CH_3 = 8'h33;
  localparam logic [7:0] CH_6 = 8'h36;
  localparam logic [7:0] CH_7 = 8'h37;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_X = 8'h58;

  typedef enum logic [1:0] {
    CFG_HEADER  = 2'd0,
    CFG_TIMEOUT = 2'd1,
    CFG_CUT_EN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_T_STATUS = 3'd0,
    KIND_T_ALARM  = 3'd1,
    KIND_F        = 3'd2,
    KIND_C        = 3'd3,
    KIND_D        = 3'd4,
    KIND_OTHER    = 3'd5,
    KIND_LINK_LOST = 3'd6
  } kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [19:0] value;
    logic        digit_error;
    logic [2:0]  limit_bits;
    logic [2:0]  z_bits;
    logic [15:0] byte_pair;
    logic [7:0]  aux_byte;
    logic [6:0]  gain;
    logic [6:0]  diff_gain;
    logic [6:0]  integral_gain;
    logic [3:0]  motion_flags;
    logic        link_up;
  } out_word_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // only meaningful when is_digit() holds
  function automatic logic [3:0] digit_val(input logic [7:0] c);
    return c[3:0];
  endfunction

  function automatic logic [6:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
    return 7'(digit_val(hi)) * 7'd10 + 7'(digit_val(lo));
  endfunction

endpackage

### rtl/servo_status_frame_receiver.sv
// Servo status frame receiver: header hunt, XOR check, frame decode and link timeout.
// A result forms in the accept cycle; it is registered in out_r, or in skid_r on a stall.
// One word per cycle while in_ready; frame store, XOR and decode all close in the accept cycle.
// in_ready is registered and drops only while the skid register holds a result.
// Reset (rst_n low, synchronous) clears control state and restores register defaults:
// header 37, timeout 2000, cut sensor enabled, link down, hunting for a header.
module servo_status_frame_receiver (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssfr_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ssfr_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  logic [7:0]  hdr_r;
  logic [15:0] timeout_r;
  logic        cut_en_r;

  logic                       in_frame_r, in_frame_nxt;
  logic [ssfr_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [7:0]                 xor_r, xor_nxt;
  logic [7:0]                 store_r [ssfr_pkg::FRAME_LEN];
  logic                       store_we;
  logic [2:0]                 limit_r, limit_nxt;
  logic [2:0]                 z_r, z_nxt;
  logic [3:0]                 flag_r, flag_nxt;
  logic [15:0]                timer_r, timer_nxt, timer_inc;
  logic                       link_r, link_nxt;

  logic                out_valid_r, skid_valid_r;
  ssfr_pkg::out_word_t out_r, skid_r;
  logic                in_acc;
  logic                res_valid;
  ssfr_pkg::out_word_t res;

  ssfr_pkg::out_word_t dec;
  logic [7:0]          cmd, b2, b3, b4;
  logic                t_bad, f_bad, g_bad, bad;
  logic [19:0]         t_val, f_val;

  assign in_ready  = !skid_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign timer_inc = (timer_r == 16'hFFFF) ? timer_r : timer_r + 16'd1;

  // frame decode from stored bytes
  always_comb begin
    cmd = store_r[1];
    b2  = store_r[2];
    b3  = store_r[3];
    b4  = store_r[4];
    t_bad = 1'b0;
    for (int i = 5; i <= 10; i++) t_bad = t_bad | !ssfr_pkg::is_digit(store_r[i]);
    f_bad = 1'b0;
    for (int i = 7; i <= 10; i++) f_bad = f_bad | !ssfr_pkg::is_digit(store_r[i]);
    g_bad = 1'b0;
    for (int i = 4; i <= 9; i++) g_bad = g_bad | !ssfr_pkg::is_digit(store_r[i]);
    t_val = 20'(ssfr_pkg::digit_val(store_r[5])) * 20'd100000
          + 20'(ssfr_pkg::digit_val(store_r[6])) * 20'd10000
          + 20'(ssfr_pkg::digit_val(store_r[7])) * 20'd1000
          + 20'(ssfr_pkg::digit_val(store_r[8])) * 20'd100
          + 20'(ssfr_pkg::digit_val(store_r[9])) * 20'd10
          + 20'(ssfr_pkg::digit_val(store_r[10]));
    f_val = 20'(ssfr_pkg::digit_val(store_r[7])) * 20'd1000
          + 20'(ssfr_pkg::digit_val(store_r[8])) * 20'd100
          + 20'(ssfr_pkg::digit_val(store_r[9])) * 20'd10
          + 20'(ssfr_pkg::digit_val(store_r[10]));

    dec = '0;
    dec.kind = ssfr_pkg::KIND_OTHER;
    dec.limit_bits = limit_r;
    dec.z_bits = z_r;
    dec.motion_flags = flag_r;
    dec.link_up = 1'b1;
    bad = 1'b0;

    unique case (cmd) inside
      ssfr_pkg::CH_T: begin
        dec.aux_byte = b2;
        if (b3 < ssfr_pkg::CH_L) begin
          dec.kind = ssfr_pkg::KIND_T_STATUS;
          if (b3 >= ssfr_pkg::CH_0 && b3 <= ssfr_pkg::CH_7) dec.limit_bits = b3[2:0];
          if (b4 >= ssfr_pkg::CH_0 && b4 <= ssfr_pkg::CH_7) begin
            dec.z_bits = b4[2:0];
            if (!cut_en_r) dec.z_bits[1] = z_r[1];
          end
          bad = t_bad;
          dec.value = t_val;
        end else begin
          dec.kind = ssfr_pkg::KIND_T_ALARM;
          dec.byte_pair = {b3, b4};
        end
      end
      ssfr_pkg::CH_F: begin
        dec.kind = ssfr_pkg::KIND_F;
        dec.aux_byte = b2;
        case (b3)
          ssfr_pkg::CH_N: dec.motion_flags[1:0] = 2'b00;
          ssfr_pkg::CH_D: dec.motion_flags[1:0] = 2'b01;
          ssfr_pkg::CH_R: dec.motion_flags[1:0] = 2'b10;
          default: ;
        endcase
        dec.byte_pair = {b4, store_r[5]};
        bad = f_bad;
        dec.value = f_val;
      end
      ssfr_pkg::CH_C, ssfr_pkg::CH_D: begin
        dec.kind = (cmd == ssfr_pkg::CH_C) ? ssfr_pkg::KIND_C : ssfr_pkg::KIND_D;
        dec.aux_byte = b3;
        case (b2) inside
          ssfr_pkg::CH_2, ssfr_pkg::CH_3: dec.motion_flags[2] = 1'b0;
          ssfr_pkg::CH_6, ssfr_pkg::CH_7: dec.motion_flags[2] = 1'b1;
          default: ;
        endcase
        if (cmd == ssfr_pkg::CH_C) begin
          if (b3 == ssfr_pkg::CH_X) dec.motion_flags[3] = 1'b1;
          else if (b3 == ssfr_pkg::CH_S) dec.motion_flags[3] = 1'b0;
        end
        bad = g_bad;
        dec.gain          = ssfr_pkg::two_digits(store_r[4], store_r[5]);
        dec.diff_gain     = ssfr_pkg::two_digits(store_r[6], store_r[7]);
        dec.integral_gain = ssfr_pkg::two_digits(store_r[8], store_r[9]);
      end
      default: ;
    endcase

    dec.digit_error = bad;
    if (bad) begin
      dec.value = '0;
      dec.gain = '0;
      dec.diff_gain = '0;
      dec.integral_gain = '0;
    end
  end

  // per-word state update
  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    xor_nxt      = xor_r;
    limit_nxt    = limit_r;
    z_nxt        = z_r;
    flag_nxt     = flag_r;
    timer_nxt    = timer_r;
    link_nxt     = link_r;
    store_we     = 1'b0;
    res_valid    = 1'b0;
    res          = '0;
    if (in_acc) begin
      if (in_data.mode) begin
        timer_nxt = timer_inc;
        if (link_r && (timer_inc > timeout_r)) begin
          link_nxt = 1'b0;
          res_valid = 1'b1;
          res.kind = ssfr_pkg::KIND_LINK_LOST;
          res.limit_bits = limit_r;
          res.z_bits = z_r;
          res.motion_flags = flag_r;
        end
      end else if (!in_frame_r) begin
        if (in_data.rx_byte == hdr_r) begin
          in_frame_nxt = 1'b1;
          count_nxt = ssfr_pkg::CNT_W'(1);
          xor_nxt = in_data.rx_byte;
          store_we = 1'b1;
        end
      end else begin
        store_we = 1'b1;
        xor_nxt = xor_r ^ in_data.rx_byte;
        if (count_r == ssfr_pkg::LAST_IDX) begin
          in_frame_nxt = 1'b0;
          count_nxt = '0;
          if (xor_r == in_data.rx_byte) begin
            link_nxt  = 1'b1;
            timer_nxt = '0;
            limit_nxt = dec.limit_bits;
            z_nxt     = dec.z_bits;
            flag_nxt  = dec.motion_flags;
            res_valid = 1'b1;
            res       = dec;
          end
        end else begin
          count_nxt = count_r + ssfr_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r      <= ssfr_pkg::HEADER_RST;
      timeout_r  <= ssfr_pkg::TIMEOUT_RST;
      cut_en_r   <= 1'b1;
      in_frame_r <= 1'b0;
      count_r    <= '0;
      limit_r    <= '0;
      z_r        <= '0;
      flag_r     <= '0;
      timer_r    <= '0;
      link_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ssfr_pkg::CFG_HEADER:  hdr_r     <= cfg_wdata[7:0];
          ssfr_pkg::CFG_TIMEOUT: timeout_r <= cfg_wdata;
          ssfr_pkg::CFG_CUT_EN:  cut_en_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      limit_r    <= limit_nxt;
      z_r        <= z_nxt;
      flag_r     <= flag_nxt;
      timer_r    <= timer_nxt;
      link_r     <= link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xor_r <= xor_nxt;
    if (store_we) store_r[count_r] <= in_data.rx_byte;
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= res_valid;
      out_r       <= res;
    end else if (res_valid) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a word while output is empty");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (count_r == '0))
    else $error("byte count nonzero while hunting");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> (count_r != '0) && (count_r <= ssfr_pkg::LAST_IDX))
    else $error("byte count out of range inside a frame");

  a_good_frame_link: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind != ssfr_pkg::KIND_LINK_LOST) |=> (link_r && timer_r == '0))
    else $error("good frame did not raise the link");

  a_link_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == ssfr_pkg::KIND_LINK_LOST) |-> link_r ##1 !link_r)
    else $error("link-lost word without link drop");

endmodule
